// ----- src/plpc_pkg.sv -----
// Shared constants, types and a helper function of the polar pose controller.
`timescale 1ns / 1ps
`default_nettype none
package plpc_pkg;

	// Fixed-point format and CORDIC depth
	localparam int FRAC_BITS     = 16;
	localparam int CORDIC_STAGES = 18;
	localparam int ANG_SHIFT     = 30 - FRAC_BITS;

	// Datapath widths
	localparam int CW  = 40;             // CORDIC x/y
	localparam int ZW  = 35;             // Q30 angle
	localparam int AW  = FRAC_BITS + 5;  // output-format angle
	localparam int DW  = 36;             // distance, unsigned
	localparam int SW  = 33;             // cos/sin Q30
	localparam int QB  = 32;             // divider quotient bits
	localparam int OW  = 21;             // velocity outputs
	localparam int UW  = 48;             // unclamped velocity

	// Pipeline depths
	localparam int CORDIC_LAT = CORDIC_STAGES + 3;
	localparam int DIV_LAT    = QB + 2;
	localparam int LINE_LEN   = CORDIC_LAT + DIV_LAT;

	// Q30 angle constants
	localparam logic signed [ZW-1:0] PI_Q30      = ZW'(64'sd3373259426);
	localparam logic signed [ZW-1:0] TWO_PI_Q30  = ZW'(64'sd6746518852);
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);
	localparam logic signed [ZW-1:0] TINY_Q30    = ZW'(64'sd1048576);
	localparam logic signed [ZW-1:0] ROUND_ANG   = ZW'(64'sd1 <<< (ANG_SHIFT - 1));
	localparam logic [29:0]          INV_GAIN_Q30 = 30'd652032874;
	localparam logic signed [CW-1:0] INV_GAIN_X   = CW'(64'sd652032874);

	localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
		ZW'(64'sd843314857), ZW'(64'sd497837829), ZW'(64'sd263043837),
		ZW'(64'sd133525159), ZW'(64'sd67021687), ZW'(64'sd33543516),
		ZW'(64'sd16775851), ZW'(64'sd8388437), ZW'(64'sd4194283),
		ZW'(64'sd2097149), ZW'(64'sd1048576), ZW'(64'sd524288),
		ZW'(64'sd262144), ZW'(64'sd131072), ZW'(64'sd65536), ZW'(64'sd32768),
		ZW'(64'sd16384), ZW'(64'sd8192), ZW'(64'sd4096), ZW'(64'sd2048),
		ZW'(64'sd1024), ZW'(64'sd512), ZW'(64'sd256), ZW'(64'sd128),
		ZW'(64'sd64), ZW'(64'sd32), ZW'(64'sd16), ZW'(64'sd8), ZW'(64'sd4),
		ZW'(64'sd2), ZW'(64'sd1), ZW'(64'sd0)
	};

	// Register map
	typedef enum logic [2:0] {
		REG_TARGET_X    = 3'd0,
		REG_TARGET_Y    = 3'd1,
		REG_GAIN_LIN    = 3'd2,
		REG_GAIN_ANG    = 3'd3,
		REG_STOP_RADIUS = 3'd4,
		REG_MAX_LIN     = 3'd5,
		REG_MAX_ANG     = 3'd6
	} cfg_reg_t;

	localparam logic signed [31:0] RST_TARGET_X    = 32'sd983040;
	localparam logic signed [31:0] RST_TARGET_Y    = -32'sd983040;
	localparam logic [19:0]        RST_GAIN_LIN    = 20'd65536;
	localparam logic [19:0]        RST_GAIN_ANG    = 20'd6554;
	localparam logic [19:0]        RST_STOP_RADIUS = 20'd6554;
	localparam logic [19:0]        RST_MAX_LIN     = 20'd26214;
	localparam logic [19:0]        RST_MAX_ANG     = 20'd19661;

	// Values that ride beside the rotation CORDIC and divider
	typedef struct packed {
		logic signed [AW-1:0] ef;
		logic signed [AW:0]   esum;
		logic signed [ZW-1:0] e30;
		logic [DW-1:0]        dlen;
	} side_t;

	// Symmetric clamp to +/- lim
	function automatic logic signed [OW-1:0] clamp_sym(input logic signed [UW-1:0] v,
			input logic [19:0] lim);
		logic signed [UW-1:0] l;
		logic signed [UW-1:0] r;
		l = UW'($signed({1'b0, lim}));
		if (v > l) begin
			r = l;
		end else if (v < -l) begin
			r = -l;
		end else begin
			r = v;
		end
		return OW'(r);
	endfunction

endpackage
`default_nettype wire

// ----- src/plpc_cordic.sv -----
// Pipelined CORDIC, vectoring or rotation, one iteration per micro-rotation stage.
`timescale 1ns / 1ps
`default_nettype none
module plpc_cordic
	import plpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 rotate,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	output logic                 out_valid,
	output logic signed [CW-1:0] x_out,
	output logic signed [CW-1:0] y_out,
	output logic signed [ZW-1:0] z_out
);

	logic [CORDIC_LAT-1:0] v_s;
	logic signed [CW-1:0]  x_s [CORDIC_LAT];
	logic signed [CW-1:0]  y_s [CORDIC_LAT];
	logic signed [ZW-1:0]  z_s [CORDIC_LAT];
	logic                  neg_s [CORDIC_LAT];
	logic signed [CW-1:0]  x_n [CORDIC_LAT];
	logic signed [CW-1:0]  y_n [CORDIC_LAT];
	logic signed [ZW-1:0]  z_n [CORDIC_LAT];
	logic                  neg_n [CORDIC_LAT];
	logic                  dir_w [CORDIC_LAT];

	// Stage logic: quadrant setup, fold, micro-rotations, sign fix
	always_comb begin
		for (int k = 0; k < CORDIC_LAT; k++) begin
			dir_w[k] = 1'b0;
		end
		// wrap the angle or move the vector into the right half plane
		x_n[0] = x_in;
		y_n[0] = y_in;
		z_n[0] = z_in;
		neg_n[0] = 1'b0;
		if (rotate) begin
			if (z_in > PI_Q30) begin
				z_n[0] = z_in - TWO_PI_Q30;
			end else if (z_in < -PI_Q30) begin
				z_n[0] = z_in + TWO_PI_Q30;
			end
		end else if (x_in[CW-1]) begin
			if (!y_in[CW-1]) begin
				z_n[0] = HALF_PI_Q30;
				x_n[0] = y_in;
				y_n[0] = -x_in;
			end else begin
				z_n[0] = -HALF_PI_Q30;
				x_n[0] = -y_in;
				y_n[0] = x_in;
			end
		end
		// fold the angle into [-pi/2, pi/2]
		x_n[1] = x_s[0];
		y_n[1] = y_s[0];
		z_n[1] = z_s[0];
		neg_n[1] = neg_s[0];
		if (rotate) begin
			if (z_s[0] > HALF_PI_Q30) begin
				z_n[1] = z_s[0] - PI_Q30;
				neg_n[1] = 1'b1;
			end else if (z_s[0] < -HALF_PI_Q30) begin
				z_n[1] = z_s[0] + PI_Q30;
				neg_n[1] = 1'b1;
			end
		end
		// one micro-rotation per stage
		for (int k = 2; k < CORDIC_LAT - 1; k++) begin
			dir_w[k] = rotate ? !z_s[k-1][ZW-1] : y_s[k-1][CW-1];
			neg_n[k] = neg_s[k-1];
			if (dir_w[k]) begin
				x_n[k] = x_s[k-1] - (y_s[k-1] >>> (k - 2));
				y_n[k] = y_s[k-1] + (x_s[k-1] >>> (k - 2));
				z_n[k] = z_s[k-1] - ATAN_TAB[k-2];
			end else begin
				x_n[k] = x_s[k-1] + (y_s[k-1] >>> (k - 2));
				y_n[k] = y_s[k-1] - (x_s[k-1] >>> (k - 2));
				z_n[k] = z_s[k-1] + ATAN_TAB[k-2];
			end
		end
		// undo the fold on the result
		x_n[CORDIC_LAT-1] = neg_s[CORDIC_LAT-2] ? -x_s[CORDIC_LAT-2] : x_s[CORDIC_LAT-2];
		y_n[CORDIC_LAT-1] = neg_s[CORDIC_LAT-2] ? -y_s[CORDIC_LAT-2] : y_s[CORDIC_LAT-2];
		z_n[CORDIC_LAT-1] = z_s[CORDIC_LAT-2];
		neg_n[CORDIC_LAT-1] = 1'b0;
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[CORDIC_LAT-2:0], in_valid};
		end
	end

	// Advance data
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < CORDIC_LAT; k++) begin
				x_s[k] <= x_n[k];
				y_s[k] <= y_n[k];
				z_s[k] <= z_n[k];
				neg_s[k] <= neg_n[k];
			end
		end
	end

	assign out_valid = v_s[CORDIC_LAT-1];
	assign x_out     = x_s[CORDIC_LAT-1];
	assign y_out     = y_s[CORDIC_LAT-1];
	assign z_out     = z_s[CORDIC_LAT-1];

endmodule
`default_nettype wire

// ----- src/plpc_div.sv -----
// Pipelined restoring divider forming the saturated sin(e)/e ratio in Q30.
`timescale 1ns / 1ps
`default_nettype none
module plpc_div
	import plpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [SW-1:0] sin_in,
	input  logic signed [ZW-1:0] ang_in,
	output logic                 out_valid,
	output logic signed [QB:0]   ratio
);

	localparam int NW = SW + 30;
	localparam int RW = ZW + QB + 1;

	logic [DIV_LAT-1:0]    v_s;
	logic [NW-1:0]         rem_s [QB+1];
	logic [QB-1:0]         q_s   [QB+1];
	logic [ZW-1:0]         den_s [QB+1];
	logic                  sgn_s [QB+1];
	logic                  ovf_s [QB+1];
	logic                  tiny_s [QB+1];
	logic signed [QB:0]    ratio_s;

	logic [SW-1:0]         snum;
	logic [ZW-1:0]         sden;
	logic [NW-1:0]         num;
	logic [NW-1:0]         rem_n [QB+1];
	logic [QB-1:0]         q_n   [QB+1];
	logic [RW-1:0]         trial [QB+1];
	logic [QB:0]           mag;

	// Take magnitudes and flag saturation before the quotient bits
	always_comb begin
		snum = sin_in[SW-1] ? SW'(-sin_in) : SW'(sin_in);
		sden = ang_in[ZW-1] ? ZW'(-ang_in) : ZW'(ang_in);
		num  = {snum, 30'b0};
		rem_n[0] = num;
		q_n[0]   = '0;
		trial[0] = '0;
		for (int j = 1; j <= QB; j++) begin
			trial[j] = RW'(rem_s[j-1]) - (RW'(den_s[j-1]) << (QB - j));
			if (!trial[j][RW-1]) begin
				rem_n[j] = trial[j][NW-1:0];
				q_n[j]   = q_s[j-1] | (QB'(1) << (QB - j));
			end else begin
				rem_n[j] = rem_s[j-1];
				q_n[j]   = q_s[j-1];
			end
		end
		mag = ovf_s[QB] ? (QB+1)'(1) << (QB - 1) : {1'b0, q_s[QB]};
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DIV_LAT-2:0], in_valid};
		end
	end

	// Advance data, one quotient bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= rem_n[0];
			q_s[0]    <= q_n[0];
			den_s[0]  <= sden;
			sgn_s[0]  <= sin_in[SW-1] ^ ang_in[ZW-1];
			ovf_s[0]  <= (RW'(num)) >= ((RW'(sden) << (QB - 1)) + RW'(sden));
			tiny_s[0] <= (ang_in > -TINY_Q30) && (ang_in < TINY_Q30);
			for (int j = 1; j <= QB; j++) begin
				rem_s[j]  <= rem_n[j];
				q_s[j]    <= q_n[j];
				den_s[j]  <= den_s[j-1];
				sgn_s[j]  <= sgn_s[j-1];
				ovf_s[j]  <= ovf_s[j-1];
				tiny_s[j] <= tiny_s[j-1];
			end
			if (tiny_s[QB]) begin
				ratio_s <= (QB+1)'(1) <<< 30;
			end else begin
				ratio_s <= sgn_s[QB] ? -$signed(mag) : $signed(mag);
			end
		end
	end

	assign out_valid = v_s[DIV_LAT-1];
	assign ratio     = ratio_s;

	// Ratio stays inside the saturation bounds
	a_ratio_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ratio <= $signed((QB+1)'(1) << (QB - 1)) &&
			ratio >= -$signed((QB+1)'(1) << (QB - 1))))
		else $error("ratio out of bounds");

	a_tiny_unity: assert property (@(posedge clk) disable iff (!arst_n)
		$past(en) && $past(tiny_s[QB]) |-> ratio == ((QB+1)'(1) <<< 30))
		else $error("small-angle ratio not unity");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		$past(en) && $past(ovf_s[QB]) && !$past(tiny_s[QB]) |->
			(ratio == ((QB+1)'(1) <<< (QB - 1)) || ratio == -((QB+1)'(1) <<< (QB - 1))))
		else $error("overflow not saturated");

endmodule
`default_nettype wire

// ----- src/polar_lyapunov_pose_controller.sv -----
// Top level of the polar-coordinate Lyapunov pose controller.
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tdata: pos_x, pos_y, quat_x, quat_y, quat_z, quat_w
//  m_axis   | out       | tdata: linear_velocity, angular_velocity; tuser: at_goal
//  cfg      | in        | cfg_index, cfg_data register write
//
// One pose enters per clock while the pipeline is not held; its path runs through
// the two chained CORDIC pipelines and the divider.
// Reset clears valid bits and restores the register defaults.
// The whole pipeline holds while the output register is full and not taken.
`timescale 1ns / 1ps
`default_nettype none
module polar_lyapunov_pose_controller
	import plpc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,  // pos_x[31:0], pos_y[63:32], quat_x[81:64],
	                               // quat_y[99:82], quat_z[117:100], quat_w[135:118]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,  // linear_velocity[20:0], angular_velocity[41:21], zero
	output logic         m_tuser,  // at_goal
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	// Configuration registers
	logic signed [31:0] target_x_q, target_y_q;
	logic [19:0]        gain_lin_q, gain_ang_q, stop_radius_q, max_lin_q, max_ang_q;

	logic en;

	// Front stages
	logic               v_s1, v_s2;
	logic signed [35:0] xx_s1, yy_s1, zz_s1, ww_s1, xy_s1, wz_s1, xz_s1, wy_s1;
	logic signed [32:0] dx_s1, dy_s1, dx_s2, dy_s2;
	logic signed [37:0] vx_s2, vy_s2;
	logic               yaw_ok_s2, nz_s2;
	logic signed [37:0] norm_w, m20_w, absm_w;

	// Vectoring CORDIC outputs
	logic                 yv_valid, bv_valid;
	logic signed [CW-1:0] yx_w, yy_w, bx_w, by_w;
	logic signed [ZW-1:0] yz_w, bz_w;
	logic [1:0]           vside_s [CORDIC_LAT];

	// Polar error stage
	logic                 v_s3;
	logic signed [AW-1:0] ef_s3, bearf_w, yawf_w, ef_w;
	logic signed [AW:0]   esum_s3;
	logic [65:0]          pm_s3;
	logic signed [ZW-1:0] yaw30_w, bear30_w, e30_w;
	side_t                side_w;
	side_t                side_s [LINE_LEN];

	// Rotation CORDIC and divider
	logic                 rot_valid, div_valid;
	logic signed [CW-1:0] rc_w, rs_w;
	logic signed [ZW-1:0] rz_w;
	logic signed [SW-1:0] cline_s [DIV_LAT];
	logic signed [QB:0]   sinc_w;
	side_t                tail_w;

	// Back stages
	logic               v_s4, v_s5, v_s6, v_s7, v_s8;
	logic signed [65:0] p1_s4;
	logic signed [69:0] pd_s4;
	logic signed [AW-1:0] ef_s4, ef_s5;
	logic signed [AW:0]   esum_s4;
	logic               goal_s4, goal_s5, goal_s6, goal_s7, goal_s8;
	logic signed [57:0] p2_s5;
	logic signed [60:0] pl_s5;
	logic signed [39:0] term_s6;
	logic signed [UW-1:0] u1_s6, u1_s7;
	logic signed [60:0] pa_s7;
	logic signed [OW-1:0] lin_s8, ang_s8;
	logic signed [35:0] cs_w;
	logic signed [39:0] dcs_w;
	logic signed [UW-1:0] u2_w, u1z_w, u2z_w;

	// Hold the pipeline only while the result waits
	assign en        = !v_s8 || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q    <= RST_TARGET_X;
			target_y_q    <= RST_TARGET_Y;
			gain_lin_q    <= RST_GAIN_LIN;
			gain_ang_q    <= RST_GAIN_ANG;
			stop_radius_q <= RST_STOP_RADIUS;
			max_lin_q     <= RST_MAX_LIN;
			max_ang_q     <= RST_MAX_ANG;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TARGET_X:    target_x_q    <= $signed(cfg_data);
				REG_TARGET_Y:    target_y_q    <= $signed(cfg_data);
				REG_GAIN_LIN:    gain_lin_q    <= cfg_data[19:0];
				REG_GAIN_ANG:    gain_ang_q    <= cfg_data[19:0];
				REG_STOP_RADIUS: stop_radius_q <= cfg_data[19:0];
				REG_MAX_LIN:     max_lin_q     <= cfg_data[19:0];
				REG_MAX_ANG:     max_ang_q     <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// Valid bits of the stages outside the submodules
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= yv_valid;
			v_s4 <= div_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Stage 1: quaternion products and offsets to the target
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= 36'($signed(s_tdata[81:64]))   * 36'($signed(s_tdata[81:64]));
			yy_s1 <= 36'($signed(s_tdata[99:82]))   * 36'($signed(s_tdata[99:82]));
			zz_s1 <= 36'($signed(s_tdata[117:100])) * 36'($signed(s_tdata[117:100]));
			ww_s1 <= 36'($signed(s_tdata[135:118])) * 36'($signed(s_tdata[135:118]));
			xy_s1 <= 36'($signed(s_tdata[81:64]))   * 36'($signed(s_tdata[99:82]));
			wz_s1 <= 36'($signed(s_tdata[135:118])) * 36'($signed(s_tdata[117:100]));
			xz_s1 <= 36'($signed(s_tdata[81:64]))   * 36'($signed(s_tdata[117:100]));
			wy_s1 <= 36'($signed(s_tdata[135:118])) * 36'($signed(s_tdata[99:82]));
			dx_s1 <= 33'($signed(s_tdata[31:0]))  - 33'(target_x_q);
			dy_s1 <= 33'($signed(s_tdata[63:32])) - 33'(target_y_q);
		end
	end

	// Stage 2: yaw vector and gimbal-lock test
	always_comb begin
		norm_w = 38'(xx_s1) + 38'(yy_s1) + 38'(zz_s1) + 38'(ww_s1);
		m20_w  = (38'(xz_s1) - 38'(wy_s1)) <<< 1;
		absm_w = m20_w[37] ? -m20_w : m20_w;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s2     <= 38'(ww_s1) + 38'(xx_s1) - 38'(yy_s1) - 38'(zz_s1);
			vy_s2     <= (38'(xy_s1) + 38'(wz_s1)) <<< 1;
			yaw_ok_s2 <= absm_w < norm_w;
			nz_s2     <= (dx_s1 != '0) || (dy_s1 != '0);
			dx_s2     <= dx_s1;
			dy_s2     <= dy_s1;
		end
	end

	plpc_cordic u_yaw_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.rotate   (1'b0),
		.in_valid (v_s2),
		.x_in     (CW'(vx_s2)),
		.y_in     (CW'(vy_s2)),
		.z_in     ('0),
		.out_valid(yv_valid),
		.x_out    (yx_w),
		.y_out    (yy_w),
		.z_out    (yz_w)
	);

	plpc_cordic u_bear_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.rotate   (1'b0),
		.in_valid (v_s2),
		.x_in     (CW'(dx_s2)),
		.y_in     (CW'(dy_s2)),
		.z_in     ('0),
		.out_valid(bv_valid),
		.x_out    (bx_w),
		.y_out    (by_w),
		.z_out    (bz_w)
	);

	// Carry the gimbal and on-target flags beside the vectoring CORDICs
	always_ff @(posedge clk) begin
		if (en) begin
			vside_s[0] <= {yaw_ok_s2, nz_s2};
			for (int k = 1; k < CORDIC_LAT; k++) begin
				vside_s[k] <= vside_s[k-1];
			end
		end
	end

	// Stage 3: round angles, heading error, distance product
	always_comb begin
		yaw30_w  = vside_s[CORDIC_LAT-1][1] ? yz_w : '0;
		bear30_w = vside_s[CORDIC_LAT-1][0] ? bz_w : '0;
		yawf_w   = AW'((yaw30_w + ROUND_ANG) >>> ANG_SHIFT);
		bearf_w  = AW'((bear30_w + ROUND_ANG) >>> ANG_SHIFT);
		ef_w     = bearf_w - yawf_w;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ef_s3   <= ef_w;
			esum_s3 <= (AW+1)'(ef_w) + (AW+1)'(bearf_w);
			pm_s3   <= vside_s[CORDIC_LAT-1][0] ?
				66'(bx_w[DW-1:0]) * 66'(INV_GAIN_Q30) : '0;
		end
	end

	assign e30_w = ZW'(ef_s3) <<< ANG_SHIFT;

	// Side line: distance is rounded on entry
	always_comb begin
		side_w.ef   = ef_s3;
		side_w.esum = esum_s3;
		side_w.e30  = e30_w;
		side_w.dlen = DW'((pm_s3 + (66'(1) << 29)) >> 30);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_w;
			for (int k = 1; k < LINE_LEN; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	plpc_cordic u_rot_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.rotate   (1'b1),
		.in_valid (v_s3),
		.x_in     (INV_GAIN_X),
		.y_in     ('0),
		.z_in     (e30_w),
		.out_valid(rot_valid),
		.x_out    (rc_w),
		.y_out    (rs_w),
		.z_out    (rz_w)
	);

	// Hold the cosine while the ratio is formed
	always_ff @(posedge clk) begin
		if (en) begin
			cline_s[0] <= rc_w[SW-1:0];
			for (int k = 1; k < DIV_LAT; k++) begin
				cline_s[k] <= cline_s[k-1];
			end
		end
	end

	plpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (rot_valid),
		.sin_in   (rs_w[SW-1:0]),
		.ang_in   (side_s[CORDIC_LAT-1].e30),
		.out_valid(div_valid),
		.ratio    (sinc_w)
	);

	assign tail_w = side_s[LINE_LEN-1];

	// Stage 4: cos*ratio, dist*cos, stop test
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s4   <= 66'(cline_s[DIV_LAT-1]) * 66'(sinc_w);
			pd_s4   <= 70'($signed({1'b0, tail_w.dlen})) * 70'(cline_s[DIV_LAT-1]);
			ef_s4   <= tail_w.ef;
			esum_s4 <= tail_w.esum;
			goal_s4 <= tail_w.dlen < DW'(stop_radius_q);
		end
	end

	// Stage 5: scale by the error sum and the linear gain
	always_comb begin
		cs_w  = 36'(p1_s4 >>> 30);
		dcs_w = 40'(pd_s4 >>> 30);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p2_s5   <= 58'(esum_s4) * 58'(cs_w);
			pl_s5   <= 61'($signed({1'b0, gain_lin_q})) * 61'(dcs_w);
			ef_s5   <= ef_s4;
			goal_s5 <= goal_s4;
		end
	end

	// Stage 6: angular term and negated linear command
	always_ff @(posedge clk) begin
		if (en) begin
			term_s6 <= 40'(ef_s5) + 40'(p2_s5 >>> 30);
			u1_s6   <= -(UW'(pl_s5 >>> FRAC_BITS));
			goal_s6 <= goal_s5;
		end
	end

	// Stage 7: angular gain
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s7   <= 61'($signed({1'b0, gain_ang_q})) * 61'(term_s6);
			u1_s7   <= u1_s6;
			goal_s7 <= goal_s6;
		end
	end

	// Stage 8: zero inside the stop radius, clamp, output register
	always_comb begin
		u2_w  = UW'(pa_s7 >>> FRAC_BITS);
		u1z_w = goal_s7 ? '0 : u1_s7;
		u2z_w = goal_s7 ? '0 : u2_w;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lin_s8  <= clamp_sym(u1z_w, max_lin_q);
			ang_s8  <= clamp_sym(u2z_w, max_ang_q);
			goal_s8 <= goal_s7;
		end
	end

	assign m_tvalid = v_s8;
	assign m_tdata  = {6'b0, ang_s8, lin_s8};
	assign m_tuser  = goal_s8;

	// At the goal both commands are zero
	a_goal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> lin_s8 == '0 && ang_s8 == '0)
		else $error("commands not zeroed at goal");

	// Commands respect the configured limits
	a_lin_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (lin_s8 <= $signed({1'b0, max_lin_q}) &&
			lin_s8 >= -$signed({1'b0, max_lin_q})))
		else $error("linear command over limit");

	a_ang_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (ang_s8 <= $signed({1'b0, max_ang_q}) &&
			ang_s8 >= -$signed({1'b0, max_ang_q})))
		else $error("angular command over limit");

	// Parallel vectoring pipelines stay in step
	a_vec_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		yv_valid == bv_valid)
		else $error("vectoring pipelines out of step");

endmodule
`default_nettype wire
